@@ src/bpa_pkg.sv @@
package bpa_pkg;

    // Zone geometry
    localparam int NUM_PAGES   = 4096;
    localparam int ORDER_COUNT = 11;
    localparam int PAGE_W      = $clog2(NUM_PAGES);
    localparam int ORD_W       = $clog2(ORDER_COUNT);
    localparam int CNT_W       = PAGE_W + 1;
    localparam int TAG_W       = ORD_W + 1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NO_BLOCK = 2'd1,
        ST_BAD      = 2'd2
    } t_status;

    // Request actions
    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [3:0]  block_order;
        logic [11:0] page_index;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [11:0] block_index;
        logic [12:0] free_total;
        logic        released_valid;
        logic [11:0] released_index;
    } t_rsp;

endpackage

@@ src/buddy_page_allocator.sv @@
// Channel | Direction | Handshake                  | Word
// req     | in        | i_req_valid / o_req_stall  | t_req: action, block_order, page_index
// rsp     | out       | o_rsp_valid / i_rsp_stall  | t_rsp: status, block, free total, release
//
// After reset a clearing pass writes every page tag to zero; no request is taken
// while it runs.
// Alloc searches upward for a listed block and splits it down order by order;
// free merges with free buddies upward and, at the top order, releases all
// but one top block. The link and tag memories have a registered read.
// A free is rejected when misaligned, out of range or already free.
// A finished word waits in the output register; the next request is taken meanwhile.
module buddy_page_allocator
    import bpa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SEARCH, S_POP, S_SPLIT, S_FCHK,
        S_MRD, S_MCHK, S_PUSH, S_RRD, S_RWR, S_DONE
    } t_state;

    t_state            r_state;
    logic [PAGE_W-1:0] r_clr;
    logic [ORD_W-1:0]  r_k;
    logic [ORD_W-1:0]  r_ord;
    logic [PAGE_W-1:0] r_idx;
    logic [PAGE_W-1:0] r_blk;
    logic [PAGE_W-1:0] r_rel;
    logic              r_relv;
    t_status           r_status;
    logic [CNT_W-1:0]  r_free;
    logic              r_out_valid;
    t_rsp              r_rsp;

    // Per-order list registers, accessed at r_k outside reset
    logic [PAGE_W-1:0] r_head  [ORDER_COUNT];
    logic [PAGE_W-1:0] r_tail  [ORDER_COUNT];
    logic [CNT_W-1:0]  r_count [ORDER_COUNT];

    // Page memories
    logic [PAGE_W-1:0] r_next_mem [NUM_PAGES];
    logic [PAGE_W-1:0] r_prev_mem [NUM_PAGES];
    logic [TAG_W-1:0]  r_tag_mem  [NUM_PAGES];
    logic [PAGE_W-1:0] r_next_q;
    logic [PAGE_W-1:0] r_prev_q;
    logic [TAG_W-1:0]  r_tag_q;

    logic [PAGE_W-1:0] rd_addr;
    logic              nx_we, pv_we, tg_we;
    logic [PAGE_W-1:0] nx_waddr, nx_wdata, pv_waddr, pv_wdata, tg_waddr;
    logic [TAG_W-1:0]  tg_wdata;

    logic [PAGE_W-1:0] cur_head, cur_tail, bud, split_pg;
    logic [CNT_W-1:0]  cur_count, req_size, ord_size, k_size;
    logic              req_order_bad, req_misaligned, req_outside;
    logic              k_vacant, list_multi, k_top;
    logic [TAG_W-1:0]  k_tag;

    assign cur_head   = r_head[r_k];
    assign cur_tail   = r_tail[r_k];
    assign cur_count  = r_count[r_k];
    assign k_vacant   = (cur_count == '0);
    assign list_multi = (cur_count > CNT_W'(1));
    assign k_top      = (r_k == ORD_W'(ORDER_COUNT - 1));
    assign k_tag      = {1'b1, r_k};
    assign bud        = r_idx ^ PAGE_W'(CNT_W'(1) << r_k);
    assign split_pg   = r_blk + PAGE_W'(CNT_W'(1) << r_k);
    assign ord_size   = CNT_W'(1) << r_ord;
    assign k_size     = CNT_W'(1) << r_k;

    // Request checks at accept
    assign req_order_bad  = ({1'b0, i_req.block_order} >= 5'(ORDER_COUNT));
    assign req_size       = CNT_W'(1) << i_req.block_order;
    assign req_misaligned = ((CNT_W'(i_req.page_index) & (req_size - CNT_W'(1))) != '0);
    assign req_outside    = ((CNT_W + 1)'(i_req.page_index) + (CNT_W + 1)'(req_size))
                            > (CNT_W + 1)'(NUM_PAGES);

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

    // Shared read address for all three page memories
    always_comb begin
        unique case (r_state)
            S_IDLE:  rd_addr = i_req.page_index;
            S_SEARCH,
            S_RRD:   rd_addr = cur_head;
            S_MRD:   rd_addr = bud;
            default: rd_addr = r_idx;
        endcase
    end

    // Memory write ports
    always_comb begin
        nx_we = 1'b0; nx_waddr = cur_tail; nx_wdata = split_pg;
        pv_we = 1'b0; pv_waddr = split_pg; pv_wdata = cur_tail;
        tg_we = 1'b0; tg_waddr = r_blk;    tg_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                tg_we = 1'b1; tg_waddr = r_clr;
            end
            S_POP: begin
                tg_we = 1'b1; tg_waddr = r_blk;
            end
            S_SPLIT: begin
                // push_tail of the upper half
                nx_we = !k_vacant; nx_waddr = cur_tail; nx_wdata = split_pg;
                pv_we = !k_vacant; pv_waddr = split_pg; pv_wdata = cur_tail;
                tg_we = 1'b1; tg_waddr = split_pg; tg_wdata = k_tag;
            end
            S_MCHK: begin
                // unlink the buddy from the middle of its list
                if (r_tag_q == k_tag && !k_vacant) begin
                    tg_we = 1'b1; tg_waddr = bud;
                    if (list_multi && bud != cur_head && bud != cur_tail) begin
                        nx_we = 1'b1; nx_waddr = r_prev_q; nx_wdata = r_next_q;
                        pv_we = 1'b1; pv_waddr = r_next_q; pv_wdata = r_prev_q;
                    end
                end
            end
            S_PUSH: begin
                nx_we = !k_vacant; nx_waddr = r_idx; nx_wdata = cur_head;
                pv_we = !k_vacant; pv_waddr = cur_head; pv_wdata = r_idx;
                tg_we = 1'b1; tg_waddr = r_idx; tg_wdata = k_tag;
            end
            S_RWR: begin
                tg_we = 1'b1; tg_waddr = r_rel;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_next_q <= r_next_mem[rd_addr];
        if (nx_we) r_next_mem[nx_waddr] <= nx_wdata;
    end

    always_ff @(posedge i_clk) begin
        r_prev_q <= r_prev_mem[rd_addr];
        if (pv_we) r_prev_mem[pv_waddr] <= pv_wdata;
    end

    always_ff @(posedge i_clk) begin
        r_tag_q <= r_tag_mem[rd_addr];
        if (tg_we) r_tag_mem[tg_waddr] <= tg_wdata;
    end

    // Sequencer, list registers and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ORDER_COUNT; i++) r_count[i] <= '0;
        end else begin
            // word leaves; S_DONE reloads it on its own
            if (r_out_valid && !i_rsp_stall && r_state != S_DONE) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + PAGE_W'(1);
                    if (r_clr == PAGE_W'(NUM_PAGES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_idx    <= i_req.page_index;
                        r_blk    <= '0;
                        r_rel    <= '0;
                        r_relv   <= 1'b0;
                        if (req_order_bad) begin
                            r_k      <= '0;
                            r_ord    <= '0;
                            r_status <= ST_BAD;
                            r_state  <= S_DONE;
                        end else begin
                            r_k   <= ORD_W'(i_req.block_order);
                            r_ord <= ORD_W'(i_req.block_order);
                            if (i_req.action == ACT_ALLOC) begin
                                r_status <= ST_DONE;
                                r_state  <= S_SEARCH;
                            end else if (req_misaligned || req_outside) begin
                                r_status <= ST_BAD;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= ST_DONE;
                                r_state  <= S_FCHK;
                            end
                        end
                    end
                end
                S_SEARCH: begin
                    if (!k_vacant) begin
                        r_blk   <= cur_head;
                        r_state <= S_POP;
                    end else if (k_top) begin
                        r_status <= ST_NO_BLOCK;
                        r_state  <= S_DONE;
                    end else begin
                        r_k <= r_k + ORD_W'(1);
                    end
                end
                S_POP: begin
                    if (list_multi) r_head[r_k] <= r_next_q;
                    r_count[r_k] <= cur_count - CNT_W'(1);
                    r_free       <= r_free - ord_size;
                    if (r_k > r_ord) begin
                        r_k     <= r_k - ORD_W'(1);
                        r_state <= S_SPLIT;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SPLIT: begin
                    if (k_vacant) r_head[r_k] <= split_pg;
                    r_tail[r_k]  <= split_pg;
                    r_count[r_k] <= cur_count + CNT_W'(1);
                    if (r_k > r_ord) r_k <= r_k - ORD_W'(1);
                    else             r_state <= S_DONE;
                end
                S_FCHK: begin
                    // double free check on the head tag
                    if (r_tag_q[TAG_W-1]) begin
                        r_status <= ST_BAD;
                        r_state  <= S_DONE;
                    end else begin
                        r_free  <= r_free + k_size;
                        r_state <= S_MRD;
                    end
                end
                S_MRD: begin
                    if (!k_top && ({1'b0, bud} < CNT_W'(NUM_PAGES))) r_state <= S_MCHK;
                    else                                            r_state <= S_PUSH;
                end
                S_MCHK: begin
                    if (r_tag_q == k_tag) begin
                        if (!k_vacant) begin
                            if (list_multi) begin
                                priority if (bud == cur_head) r_head[r_k] <= r_next_q;
                                else if (bud == cur_tail)     r_tail[r_k] <= r_prev_q;
                            end
                            r_count[r_k] <= cur_count - CNT_W'(1);
                        end
                        r_k     <= r_k + ORD_W'(1);
                        r_idx   <= r_idx & bud;
                        r_state <= S_MRD;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (k_vacant) r_tail[r_k] <= r_idx;
                    r_head[r_k]  <= r_idx;
                    r_count[r_k] <= cur_count + CNT_W'(1);
                    r_blk        <= r_idx;
                    r_state      <= k_top ? S_RRD : S_DONE;
                end
                S_RRD: begin
                    if (list_multi) begin
                        r_rel   <= cur_head;
                        r_state <= S_RWR;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_RWR: begin
                    r_head[r_k]  <= r_next_q;
                    r_count[r_k] <= cur_count - CNT_W'(1);
                    r_free       <= r_free - k_size;
                    r_relv       <= 1'b1;
                    r_state      <= S_RRD;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_rsp_stall) begin
                        r_out_valid          <= 1'b1;
                        r_rsp.status         <= r_status;
                        r_rsp.block_index    <= (r_status == ST_DONE) ? r_blk : '0;
                        r_rsp.free_total     <= r_free;
                        r_rsp.released_valid <= r_relv;
                        r_rsp.released_index <= r_rel;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/bpa_checker.sv @@
module bpa_checker
    import bpa_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_stall,
    input t_req i_req,
    input logic o_rsp_valid,
    input logic i_rsp_stall,
    input t_rsp o_rsp
);

    // No undefined status code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.status == ST_DONE || o_rsp.status == ST_NO_BLOCK
                         || o_rsp.status == ST_BAD))
        else $error("bpa: bad status code");

    // A release only comes with a completed free
    a_release_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.released_valid) |-> (o_rsp.status == ST_DONE))
        else $error("bpa: release on failed request");

    // Failed requests report zero block and no release
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status != ST_DONE) |->
        (o_rsp.block_index == '0 && !o_rsp.released_valid && o_rsp.released_index == '0))
        else $error("bpa: failed request carries data");

    // Stalled word holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_stall) |=> (o_rsp_valid && $stable(o_rsp)))
        else $error("bpa: stalled word changed");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);

@@ bench/tb_buddy_page_allocator.sv @@
module tb_buddy_page_allocator;
    import bpa_pkg::*;

    localparam int TOP_ORDER   = ORDER_COUNT - 1;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 4 * ORDER_COUNT + 40;

    // Allocated block held by the bench until it is freed again
    typedef struct packed {
        logic [3:0]  block_order;
        logic [11:0] page_index;
    } t_owned;

    // Buddy state mirror plus queue of expected response words
    class alloc_scoreboard;
        logic [11:0] nxt_pg [NUM_PAGES];
        logic [11:0] prv_pg [NUM_PAGES];
        logic [4:0]  pg_tag [NUM_PAGES];
        logic [11:0] head_pg [ORDER_COUNT];
        logic [11:0] tail_pg [ORDER_COUNT];
        int          blk_cnt [ORDER_COUNT];
        logic [12:0] pages_free;
        t_rsp        rsp_q [$];
        t_owned      owned [$];
        int          errors;

        function new();
            foreach (pg_tag[i]) pg_tag[i] = '0;
            foreach (blk_cnt[i]) blk_cnt[i] = 0;
            pages_free = '0;
            errors = 0;
        endfunction

        function void link_front(int o, logic [11:0] p);
            if (blk_cnt[o] == 0) begin
                head_pg[o] = p;
                tail_pg[o] = p;
            end else begin
                nxt_pg[p] = head_pg[o];
                prv_pg[head_pg[o]] = p;
                head_pg[o] = p;
            end
            blk_cnt[o]++;
            pg_tag[p] = {1'b1, 4'(o)};
        endfunction

        function void link_back(int o, logic [11:0] p);
            if (blk_cnt[o] == 0) begin
                head_pg[o] = p;
                tail_pg[o] = p;
            end else begin
                prv_pg[p] = tail_pg[o];
                nxt_pg[tail_pg[o]] = p;
                tail_pg[o] = p;
            end
            blk_cnt[o]++;
            pg_tag[p] = {1'b1, 4'(o)};
        endfunction

        function void unlink(int o, logic [11:0] p);
            if (blk_cnt[o] == 0) return;
            if (blk_cnt[o] > 1) begin
                if (p == head_pg[o]) head_pg[o] = nxt_pg[p];
                else if (p == tail_pg[o]) tail_pg[o] = prv_pg[p];
                else begin
                    nxt_pg[prv_pg[p]] = nxt_pg[p];
                    prv_pg[nxt_pg[p]] = prv_pg[p];
                end
            end
            blk_cnt[o]--;
            pg_tag[p] = '0;
        endfunction

        function logic [11:0] take_head(int o);
            logic [11:0] p;
            p = head_pg[o];
            unlink(o, p);
            return p;
        endfunction

        // Predict the response for one accepted request word
        function void note(t_req r);
            t_rsp e;
            int   o, k, sz;
            logic [11:0] idx, bud;
            e = '0;
            e.status = ST_DONE;
            o = r.block_order;
            idx = r.page_index;
            if (o >= ORDER_COUNT) begin
                e.status = ST_BAD;
            end else if (r.action == ACT_ALLOC) begin
                k = o;
                while (k < ORDER_COUNT && blk_cnt[k] == 0) k++;
                if (k >= ORDER_COUNT) begin
                    e.status = ST_NO_BLOCK;
                end else begin
                    e.block_index = take_head(k);
                    pages_free = pages_free - 13'(1 << o);
                    while (k > o) begin
                        k--;
                        link_back(k, e.block_index + 12'(1 << k));
                    end
                    owned.push_back({4'(o), e.block_index});
                end
            end else begin
                sz = 1 << o;
                if ((int'(idx) & (sz - 1)) != 0 || int'(idx) + sz > NUM_PAGES
                        || pg_tag[idx][4]) begin
                    e.status = ST_BAD;
                end else begin
                    pages_free = pages_free + 13'(sz);
                    while (o < TOP_ORDER) begin
                        bud = idx ^ 12'(1 << o);
                        if (pg_tag[bud] != {1'b1, 4'(o)}) break;
                        unlink(o, bud);
                        o++;
                        idx = idx & bud;
                    end
                    link_front(o, idx);
                    e.block_index = idx;
                    // keep a single top-order block in the zone
                    if (o == TOP_ORDER) begin
                        while (blk_cnt[o] > 1) begin
                            e.released_index = take_head(o);
                            e.released_valid = 1'b1;
                            pages_free = pages_free - 13'(1 << o);
                        end
                    end
                end
            end
            e.free_total = pages_free;
            rsp_q.push_back(e);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check(t_rsp g);
            t_rsp e;
            if (rsp_q.size() == 0) begin
                report("unexpected word, status", g.status, -1);
                return;
            end
            e = rsp_q.pop_front();
            if (g.status !== e.status) report("status", g.status, e.status);
            if (g.block_index !== e.block_index)
                report("block_index", g.block_index, e.block_index);
            if (g.free_total !== e.free_total)
                report("free_total", g.free_total, e.free_total);
            if (g.released_valid !== e.released_valid)
                report("released_valid", g.released_valid, e.released_valid);
            if (g.released_index !== e.released_index)
                report("released_index", g.released_index, e.released_index);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_stall;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_stall;
    t_rsp o_rsp;

    alloc_scoreboard sb;
    int  cycles;
    bit  quiet;

    buddy_page_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Mostly short gaps, a few long ones
    function int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one request word and hold it until taken
    task send(t_action act, int ord, int idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_req_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_req_valid = 1'b1;
        i_req = '{action: act, block_order: 4'(ord), page_index: 12'(idx)};
        do @(posedge i_clk); while (o_req_stall);
        sb.note(i_req);
    endtask

    task free_owned();
        int     n;
        t_owned b;
        n = $urandom_range(0, sb.owned.size() - 1);
        b = sb.owned[n];
        sb.owned.delete(n);
        send(ACT_FREE, b.block_order, b.page_index);
    endtask

    // Drop valid, then wait for every outstanding response
    task drain();
        @(negedge i_clk);
        i_req_valid = 1'b0;
        while (sb.rsp_q.size() != 0) @(posedge i_clk);
    endtask

    // Response side stall pattern
    initial begin
        int hold;
        i_rsp_stall = 1'b0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (quiet) begin
                i_rsp_stall = 1'b0;
            end else begin
                i_rsp_stall = ($urandom_range(0, 99) < 30);
                if (i_rsp_stall) hold = ($urandom_range(0, 19) == 0) ?
                    $urandom_range(10, 40) : $urandom_range(0, 2);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) sb.check(o_rsp);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int r, o;
        sb = new();
        cycles = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_req = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty zone, bad orders, misaligned, double free, release
        send(ACT_ALLOC, 0, 0);
        send(ACT_ALLOC, 15, 4095);
        send(ACT_FREE, 11, 0);
        send(ACT_FREE, 15, 4095);
        send(ACT_FREE, 3, 5);
        send(ACT_FREE, TOP_ORDER, 0);
        send(ACT_FREE, TOP_ORDER, 0);
        send(ACT_FREE, TOP_ORDER, 3072);
        send(ACT_ALLOC, 0, 4095);
        send(ACT_ALLOC, 0, 0);
        send(ACT_ALLOC, 3, 0);
        send(ACT_ALLOC, TOP_ORDER, 0);
        send(ACT_FREE, 0, 2048);
        send(ACT_FREE, 0, 2049);
        send(ACT_ALLOC, 1, 0);
        // overlapping free inside a free block
        send(ACT_FREE, 0, 512);
        while (sb.owned.size() != 0) free_owned();

        // Sender holds off until every response is back
        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        // Random: mostly alloc/free of owned blocks, some fresh frees and noise
        for (int i = 0; i < 600; i++) begin
            if (i % 150 == 100) quiet = 1'b1;
            if (i % 150 == 130) quiet = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 40) begin
                o = ($urandom_range(0, 9) == 0) ? $urandom_range(0, TOP_ORDER)
                                                : $urandom_range(0, 3);
                send(ACT_ALLOC, o, $urandom_range(0, 4095));
            end else if (r < 75 && sb.owned.size() != 0) begin
                free_owned();
            end else if (r < 88) begin
                o = ($urandom_range(0, 3) == 0) ? TOP_ORDER
                                                : $urandom_range(0, TOP_ORDER);
                send(ACT_FREE, o, $urandom_range(0, 4095) & ~((1 << o) - 1));
            end else begin
                send(t_action'($urandom_range(0, 1)), $urandom_range(0, 15),
                     $urandom_range(0, 4095));
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.rsp_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
